// File: src/mprs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mprs_pkg
// Shared types and constants for the min-plus relaxation sweep block.
// ----------------------------------------------------------------------------
package mprs_pkg;

  // Fixed field widths of the stream payloads.
  localparam int unsigned IDX_W       = 16;
  localparam int unsigned POT_W       = 32;
  localparam int unsigned THR_W       = 31;
  localparam int unsigned ACT_W       = 2;
  localparam int unsigned LANE_OUT_W  = 4;
  localparam int unsigned MASK_OUT_W  = 16;
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 72;

  // Action codes carried on in_tuser.
  localparam logic [ACT_W-1:0] ACT_LOAD   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RELAX  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;
  // Action code that the block ignores.
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  // Saturation limits of a Q16.16 potential.
  localparam logic signed [POT_W-1:0] POT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [POT_W-1:0] POT_MIN = 32'sh8000_0000;

  // Item sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QUOT,
    ST_SLOT,
    ST_READ,
    ST_EXEC
  } state_t;

  // Access strobes from the sequencer to the potential store.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

// File: src/mprs_slot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mprs_slot
// Two-stage index reduction: node index modulo NODE_COUNT through a
// reciprocal multiply, a back multiply and one corrective subtract.
// ----------------------------------------------------------------------------
module mprs_slot
  import mprs_pkg::*;
#(
  parameter int unsigned NODE_COUNT = 65536,
  parameter int unsigned AW         = 16
) (
  input  logic             clk,
  input  logic [IDX_W-1:0] idx,
  output logic [AW-1:0]    slot
);

  localparam longint unsigned RECIP = (64'd1 << 32) / NODE_COUNT + 64'd1;
  localparam int unsigned     RW    = 29;
  localparam int unsigned     PW    = IDX_W + RW;
  localparam int unsigned     NW    = 41;

  logic [PW-1:0]    prod;
  logic [IDX_W-1:0] quot_r;
  logic [IDX_W-1:0] idx_r;
  logic [NW-1:0]    back;
  logic [NW-1:0]    rem;
  logic [NW-1:0]    rem_fix;
  logic [AW-1:0]    slot_r;

  // Stage one: quotient estimate from the reciprocal.
  assign prod = {{RW{1'b0}}, idx} * PW'(RECIP[RW-1:0]);

  always_ff @(posedge clk) begin
    quot_r <= IDX_W'(prod[PW-1:32]);
    idx_r  <= idx;
  end

  // Stage two: remainder, corrected once when the estimate was one short.
  assign back    = NW'(quot_r) * NW'(NODE_COUNT);
  assign rem     = NW'(idx_r) - back;
  assign rem_fix = (rem >= NW'(NODE_COUNT)) ? rem - NW'(NODE_COUNT) : rem;

  always_ff @(posedge clk) begin
    slot_r <= rem_fix[AW-1:0];
  end

  assign slot = slot_r;

endmodule

// File: src/mprs_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mprs_store
// Potential store: one write port and two registered read ports.
// ----------------------------------------------------------------------------
module mprs_store
  import mprs_pkg::*;
#(
  parameter int unsigned NODE_COUNT = 65536,
  parameter int unsigned AW         = 16
) (
  input  logic             clk,
  input  mem_ctl_t         ctl,
  input  logic [AW-1:0]    wr_addr,
  input  logic [POT_W-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr_a,
  input  logic [AW-1:0]    rd_addr_b,
  output logic [POT_W-1:0] rd_data_a,
  output logic [POT_W-1:0] rd_data_b
);

  logic [POT_W-1:0] mem [NODE_COUNT];
  logic [POT_W-1:0] rd_a_r;
  logic [POT_W-1:0] rd_b_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read ports; data holds between reads.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

// File: src/mprs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mprs_ctrl
// Item sequencer: holds the accepted item, drives the store, folds edges into
// the running minimum, closes nodes and owns the result register.
// ----------------------------------------------------------------------------
module mprs_ctrl
  import mprs_pkg::*;
#(
  parameter int unsigned EDGES_PER_NODE = 8,
  parameter int unsigned LANES          = 16,
  parameter int unsigned AW             = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [ACT_W-1:0]       in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  input  logic [THR_W-1:0]       threshold,
  output logic [IDX_W-1:0]       node_idx,
  output logic [IDX_W-1:0]       tgt_idx,
  input  logic [AW-1:0]          node_slot,
  output mem_ctl_t               mem_ctl,
  output logic [AW-1:0]          wr_addr,
  output logic [POT_W-1:0]       wr_data,
  input  logic [POT_W-1:0]       tgt_pot,
  input  logic [POT_W-1:0]       node_pot
);

  localparam int unsigned ECW = (EDGES_PER_NODE > 1) ? $clog2(EDGES_PER_NODE) : 1;
  localparam int unsigned LW  = (LANES > 1) ? $clog2(LANES) : 1;
  localparam logic [ECW-1:0] EDGE_LAST = ECW'(EDGES_PER_NODE - 1);
  localparam logic [LW-1:0]  LANE_LAST = LW'(LANES - 1);

  state_t state_r, state_nxt;

  logic [ACT_W-1:0]        act_r;
  logic [IDX_W-1:0]        node_r;
  logic [IDX_W-1:0]        tgt_r;
  logic signed [POT_W-1:0] val_r;

  logic signed [POT_W-1:0] min_r, min_nxt;
  logic [ECW-1:0]          edge_r, edge_nxt;
  logic [LW-1:0]           lane_r, lane_nxt;
  logic [LANES-1:0]        mask_r, mask_nxt;

  logic                    out_valid_r;
  logic [OUT_TDATA_W-1:0]  out_data_r, out_data_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    accept;
  logic                    out_free;
  logic                    emit;
  logic                    is_close;
  logic                    changed;
  logic                    seg_end;
  logic signed [POT_W:0]   sum_wide;
  logic signed [POT_W-1:0] sum_sat;
  logic signed [POT_W-1:0] min_new;
  logic signed [POT_W:0]   diff;
  logic [LANES-1:0]        mask_upd;
  logic [MASK_OUT_W-1:0]   mask_out;
  logic [LANE_OUT_W-1:0]   lane_out;

  assign accept   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign node_idx = node_r;
  assign tgt_idx  = tgt_r;

  // Saturating sum of the target potential and the edge weight.
  assign sum_wide = {tgt_pot[POT_W-1], tgt_pot} + {val_r[POT_W-1], val_r};
  always_comb begin
    if (sum_wide[POT_W] != sum_wide[POT_W-1]) begin
      sum_sat = sum_wide[POT_W] ? POT_MIN : POT_MAX;
    end else begin
      sum_sat = sum_wide[POT_W-1:0];
    end
  end
  assign min_new = (sum_sat < min_r) ? sum_sat : min_r;

  // Node close: compare the current potential against the new minimum.
  assign is_close = (edge_r == EDGE_LAST);
  assign diff     = $signed({node_pot[POT_W-1], node_pot}) - $signed({min_new[POT_W-1], min_new});
  assign changed  = is_close && (act_r == ACT_RELAX) &&
                    (diff > $signed({2'b00, threshold}));
  assign seg_end  = (lane_r == LANE_LAST);
  assign mask_upd = mask_r | (LANES'(changed) << lane_r);

  // Reported mask and lane are cut or widened to their port widths.
  always_comb begin
    for (int i = 0; i < MASK_OUT_W; i++) begin
      mask_out[i] = (i < LANES) ? mask_upd[i % LANES] : 1'b0;
    end
    for (int i = 0; i < LANE_OUT_W; i++) begin
      lane_out[i] = (i < LW) ? lane_r[i % LW] : 1'b0;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_tuser != ACT_UNUSED) begin
          state_nxt = ST_QUOT;
        end
      end
      ST_QUOT: state_nxt = ST_SLOT;
      ST_SLOT: state_nxt = ST_READ;
      ST_READ: begin
        state_nxt = (act_r == ACT_LOAD) ? ST_IDLE : ST_EXEC;
      end
      ST_EXEC: begin
        if (act_r == ACT_RELAX && !is_close) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer and next values of the working registers.
  always_comb begin
    in_tready     = 1'b0;
    mem_ctl.wr_en = 1'b0;
    mem_ctl.rd_en = 1'b0;
    wr_addr       = node_slot;
    wr_data       = val_r;
    emit          = 1'b0;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    min_nxt       = min_r;
    edge_nxt      = edge_r;
    lane_nxt      = lane_r;
    mask_nxt      = mask_r;
    case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_READ: begin
        mem_ctl.wr_en = (act_r == ACT_LOAD);
        mem_ctl.rd_en = (act_r != ACT_LOAD);
      end
      ST_EXEC: begin
        if (act_r == ACT_READ) begin
          emit         = out_free;
          out_data_nxt = {3'd0, MASK_OUT_W'(0), LANE_OUT_W'(0), 1'b0, node_pot, node_r};
          out_last_nxt = 1'b0;
        end else if (!is_close) begin
          min_nxt  = min_new;
          edge_nxt = edge_r + ECW'(1);
        end else if (out_free) begin
          emit          = 1'b1;
          mem_ctl.wr_en = changed;
          wr_data       = min_new;
          out_data_nxt  = {3'd0, mask_out, lane_out, changed, min_new, node_r};
          out_last_nxt  = seg_end;
          min_nxt       = POT_MAX;
          edge_nxt      = '0;
          lane_nxt      = seg_end ? '0 : lane_r + LW'(1);
          mask_nxt      = seg_end ? '0 : mask_upd;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      min_r       <= POT_MAX;
      edge_r      <= '0;
      lane_r      <= '0;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      min_r   <= min_nxt;
      edge_r  <= edge_nxt;
      lane_r  <= lane_nxt;
      mask_r  <= mask_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item and result payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r  <= in_tuser;
      node_r <= in_tdata[15:0];
      tgt_r  <= in_tdata[31:16];
      val_r  <= in_tdata[63:32];
    end
    if (emit) begin
      out_data_r <= out_data_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // A new item is only taken once the previous one has left the sequencer.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tuser != ACT_UNUSED) |=> !in_tready)
    else $error("sequencer took an item while busy");

  // The store is never written and read in the same cycle.
  a_mem_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_ctl.wr_en && mem_ctl.rd_en))
    else $error("store written and read together");

  // A lowered node always shows its own bit in the reported mask.
  a_changed_in_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && changed) |=> (out_tdata[53 + 32'(out_tdata[52:49])] || LANES > MASK_OUT_W))
    else $error("changed node missing from mask");

  // The store is written at a node close only while the result is registered for output.
  a_close_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && mem_ctl.wr_en) |-> (emit && is_close))
    else $error("close write without a result");

endmodule

// File: src/min_plus_relaxation_sweep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_plus_relaxation_sweep
// Min-plus relaxation over a store of signed Q16.16 node potentials.
//
//   Channel   Direction  Payload
//   in_*      input      tdata: node_index[15:0], target_index[31:16],
//                        value[63:32]; tuser: action[1:0]
//   out_*     output     tdata: out_node[15:0], potential[47:16],
//                        changed[48], lane[52:49], changed_mask[68:53];
//                        tlast: segment_end
//   cfg_*     input      cfg_data: change_threshold[30:0]
//
// A relax or read item passes through acceptance, two index reduction stages,
// the store read, and the edge fold or node close before the next item is
// taken. A load writes the store in its store read step and ends there; an
// item with the unused action is dropped in its acceptance cycle. A closing or
// read item stalls in its last cycle while an untaken result is held. Reset
// clears the sequencer, counters and threshold; the store is not cleared.
// ----------------------------------------------------------------------------
module min_plus_relaxation_sweep
  import mprs_pkg::*;
#(
  parameter int unsigned NODE_COUNT     = 65536,
  parameter int unsigned EDGES_PER_NODE = 8,
  parameter int unsigned LANES          = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // node_index[15:0], target_index[31:16], value[63:32]
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // action[1:0]
  input  logic [ACT_W-1:0]       in_tuser,
  // out_node[15:0], potential[47:16], changed[48], lane[52:49],
  // changed_mask[68:53], zero pad[71:69]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [THR_W-1:0]       cfg_data
);

  localparam int unsigned AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

  logic [THR_W-1:0] threshold_r;
  logic [IDX_W-1:0] node_idx;
  logic [IDX_W-1:0] tgt_idx;
  logic [AW-1:0]    node_slot;
  logic [AW-1:0]    tgt_slot;
  mem_ctl_t         mem_ctl;
  logic [AW-1:0]    wr_addr;
  logic [POT_W-1:0] wr_data;
  logic [POT_W-1:0] tgt_pot;
  logic [POT_W-1:0] node_pot;

  // Threshold register; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      threshold_r <= cfg_data;
    end
  end

  // Index reduction for the node and the edge target.
  mprs_slot #(.NODE_COUNT(NODE_COUNT), .AW(AW)) u_node_slot (
    .clk  (clk),
    .idx  (node_idx),
    .slot (node_slot)
  );

  mprs_slot #(.NODE_COUNT(NODE_COUNT), .AW(AW)) u_tgt_slot (
    .clk  (clk),
    .idx  (tgt_idx),
    .slot (tgt_slot)
  );

  // Potential store.
  mprs_store #(.NODE_COUNT(NODE_COUNT), .AW(AW)) u_store (
    .clk       (clk),
    .ctl       (mem_ctl),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (tgt_slot),
    .rd_addr_b (node_slot),
    .rd_data_a (tgt_pot),
    .rd_data_b (node_pot)
  );

  // Sequencer and result register.
  mprs_ctrl #(
    .EDGES_PER_NODE (EDGES_PER_NODE),
    .LANES          (LANES),
    .AW             (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .threshold  (threshold_r),
    .node_idx   (node_idx),
    .tgt_idx    (tgt_idx),
    .node_slot  (node_slot),
    .mem_ctl    (mem_ctl),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .tgt_pot    (tgt_pot),
    .node_pot   (node_pot)
  );

endmodule

// File: test/min_plus_relaxation_sweep_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_plus_relaxation_sweep_tb
// Self-checking bench for the min-plus relaxation sweep. A queue of load,
// relax and read transactions feeds a stream driver. Every accepted input
// runs through a local model of the potential store, the per-node running
// minimum and the segment mask, which queues the result it predicts. The
// monitor checks every result transaction against that queue, field by
// field. The run moves through several threshold settings and through
// phases of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module min_plus_relaxation_sweep_tb
  import mprs_pkg::*;
();

  localparam int unsigned EDGES_PER_NODE = 8;
  localparam int unsigned LANES          = 16;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS    = 110;
  localparam int unsigned MAX_REPORTS    = 10;

  typedef struct packed {
    logic [ACT_W-1:0]        action;
    logic [IDX_W-1:0]        node;
    logic [IDX_W-1:0]        target;
    logic signed [POT_W-1:0] value;
  } sweep_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]        node;
    logic signed [POT_W-1:0] potential;
    logic                    changed;
    logic [LANE_OUT_W-1:0]   lane;
    logic [MASK_OUT_W-1:0]   mask;
    logic                    seg_end;
  } sweep_result_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [ACT_W-1:0]       in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [THR_W-1:0]       cfg_data;

  // Pending input transactions and predicted results.
  sweep_item_t   pending_items[$];
  sweep_result_t expected_results[$];
  bit            in_pending;

  // Model of the block state.
  logic signed [POT_W-1:0] potential_model [0:65535];
  logic signed [POT_W-1:0] running_min;
  int unsigned             edge_count;
  int unsigned             lane_count;
  logic [MASK_OUT_W-1:0]   mask_acc;
  int unsigned             threshold;

  // Stimulus-side record of which nodes hold a loaded potential.
  bit               node_loaded [0:65535];
  logic [IDX_W-1:0] loaded_nodes[$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned idle_cycles;
  int unsigned error_count;

  min_plus_relaxation_sweep u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Update the model with one accepted transaction and queue its result.
  function automatic void relax_step(input sweep_item_t it);
    sweep_result_t res;
    longint        sum;
    longint        diff;
    res = '0;
    case (it.action)
      ACT_LOAD: potential_model[it.node] = it.value;
      ACT_READ: begin
        res.node      = it.node;
        res.potential = potential_model[it.node];
        expected_results.push_back(res);
      end
      ACT_RELAX: begin
        // Saturating sum of target potential and edge weight.
        sum = longint'(potential_model[it.target]) + longint'(it.value);
        if (sum > longint'(POT_MAX)) sum = longint'(POT_MAX);
        if (sum < longint'(POT_MIN)) sum = longint'(POT_MIN);
        if (sum < longint'(running_min)) running_min = sum[POT_W-1:0];
        edge_count++;
        if (edge_count == EDGES_PER_NODE) begin
          // Close the node named by the last edge of the group.
          diff = longint'(potential_model[it.node]) - longint'(running_min);
          res.node      = it.node;
          res.potential = running_min;
          res.changed   = (diff > longint'(threshold));
          res.lane      = lane_count[LANE_OUT_W-1:0];
          if (res.changed) begin
            potential_model[it.node] = running_min;
            mask_acc = mask_acc | (16'd1 << lane_count);
          end
          res.mask    = mask_acc;
          res.seg_end = (lane_count + 1 >= LANES);
          expected_results.push_back(res);
          edge_count  = 0;
          running_min = POT_MAX;
          if (res.seg_end) begin
            lane_count = 0;
            mask_acc   = '0;
          end else begin
            lane_count++;
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Drive the input and result channels at the falling edge.
  always @(negedge clk) begin
    if (!in_pending && pending_items.size() > 0 &&
        $urandom_range(0, 99) >= send_idle_pct) begin
      in_tvalid  <= 1'b1;
      in_tdata   <= {pending_items[0].value, pending_items[0].target,
                     pending_items[0].node};
      in_tuser   <= pending_items[0].action;
      in_pending = 1'b1;
    end else if (!in_pending) begin
      in_tvalid <= 1'b0;
    end
    out_tready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Input side: predict results for each accepted transaction.
  always @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      relax_step(pending_items.pop_front());
      in_pending = 1'b0;
    end
  end

  // Result side: check each result transaction and track progress.
  always @(posedge clk) begin
    sweep_result_t got;
    sweep_result_t want;
    if (out_tvalid && out_tready) begin
      got.node      = out_tdata[15:0];
      got.potential = out_tdata[47:16];
      got.changed   = out_tdata[48];
      got.lane      = out_tdata[52:49];
      got.mask      = out_tdata[68:53];
      got.seg_end   = out_tlast;
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("Unexpected result: node %h potential %h", got.node, got.potential);
      end else begin
        want = expected_results.pop_front();
        if (got.node !== want.node || got.potential !== want.potential ||
            got.changed !== want.changed || got.lane !== want.lane ||
            got.mask !== want.mask || got.seg_end !== want.seg_end) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("Result differs: expected node %h pot %h chg %b lane %0d mask %h end %b",
                     want.node, want.potential, want.changed, want.lane, want.mask,
                     want.seg_end);
            $display("  got node %h pot %h chg %b lane %0d mask %h end %b",
                     got.node, got.potential, got.changed, got.lane, got.mask,
                     got.seg_end);
          end
        end
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
  end

  // Stop a run in which no transaction moves for too long.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("min_plus_relaxation_sweep: mismatch");
    $finish;
  end

  // Queue one input transaction and note loaded nodes.
  task automatic push_item(input logic [ACT_W-1:0] action, input logic [IDX_W-1:0] node,
                           input logic [IDX_W-1:0] target,
                           input logic signed [POT_W-1:0] value);
    sweep_item_t it;
    it = '{action: action, node: node, target: target, value: value};
    pending_items.push_back(it);
    if (action == ACT_LOAD && !node_loaded[node]) begin
      node_loaded[node] = 1'b1;
      loaded_nodes.push_back(node);
    end
  endtask

  function automatic logic [IDX_W-1:0] pick_loaded();
    return loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)];
  endfunction

  // Potentials and weights: full range, small steps and the extremes.
  function automatic logic signed [POT_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return POT_MAX;
      1:       return POT_MIN;
      2:       return $signed($urandom_range(0, 2000)) - 1000;
      3:       return $signed($urandom) >>> 8;
      default: return $urandom;
    endcase
  endfunction

  // Random traffic, mostly whole edge groups with some noise in between.
  task automatic add_random(input int unsigned n_items);
    int unsigned      count;
    int unsigned      roll;
    bit               broken;
    logic [IDX_W-1:0] node;
    count = 0;
    while (count < n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
        node   = pick_loaded();
        broken = ($urandom_range(0, 19) == 0);
        for (int e = 0; e < EDGES_PER_NODE; e++) begin
          if ($urandom_range(0, 9) == 0) begin
            if ($urandom_range(0, 1))
              push_item(ACT_LOAD, pick_loaded(), IDX_W'($urandom), pick_value());
            else
              push_item(ACT_READ, pick_loaded(), IDX_W'($urandom), $urandom);
            count++;
          end
          if (broken) node = pick_loaded();
          push_item(ACT_RELAX, node, pick_loaded(), pick_value());
          count++;
        end
      end else if (roll < 85) begin
        push_item(ACT_LOAD, $urandom_range(0, 1) ? IDX_W'($urandom) : pick_loaded(),
                  IDX_W'($urandom), pick_value());
        count++;
      end else if (roll < 95) begin
        push_item(ACT_READ, pick_loaded(), IDX_W'($urandom), $urandom);
        count++;
      end else begin
        push_item(ACT_UNUSED, IDX_W'($urandom), IDX_W'($urandom), $urandom);
      end
    end
  endtask

  // Wait for all transactions to finish, then for the block to settle.
  task automatic drain();
    while (pending_items.size() > 0 || in_pending || expected_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] thr);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= thr;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    threshold = thr;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Main sequence: reset, directed items, then random phases.
  initial begin
    int unsigned      send_pcts [4];
    int unsigned      recv_pcts [4];
    logic [THR_W-1:0] thr_values [4];
    send_pcts  = '{0, 66, 0, 23};
    recv_pcts  = '{0, 0, 66, 23};
    thr_values = '{31'h7FFF_FFFF, 31'd1, THR_W'($urandom_range(0, 32'h0002_0000)), 31'd0};
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    out_tready     = 1'b0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    in_pending     = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    error_count    = 0;
    running_min    = POT_MAX;
    edge_count     = 0;
    lane_count     = 0;
    mask_acc       = '0;
    threshold      = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme potentials, saturation both ways, a group broken by
    // a load and a read, a closing node other than the group's first, and
    // the unused action.
    push_item(ACT_LOAD, 16'h0000, 16'hFFFF, POT_MAX);
    push_item(ACT_LOAD, 16'hFFFF, 16'h0000, POT_MIN);
    push_item(ACT_LOAD, 16'h5A5A, 16'hA5A5, 32'sd0);
    push_item(ACT_LOAD, 16'hA5A5, 16'h5A5A, 32'sh0001_0000);
    push_item(ACT_READ, 16'h0000, 16'h0000, 32'sd0);
    push_item(ACT_READ, 16'hFFFF, 16'hFFFF, -32'sd1);
    push_item(ACT_UNUSED, 16'hFFFF, 16'hFFFF, -32'sd1);
    push_item(ACT_RELAX, 16'hA5A5, 16'h0000, POT_MAX);
    push_item(ACT_RELAX, 16'hA5A5, 16'hFFFF, POT_MIN);
    push_item(ACT_LOAD, 16'h5A5A, 16'h0000, -32'sh0002_0000);
    push_item(ACT_RELAX, 16'hA5A5, 16'h5A5A, -32'sd1);
    push_item(ACT_READ, 16'h5A5A, 16'hFFFF, 32'sd0);
    push_item(ACT_RELAX, 16'hA5A5, 16'hA5A5, 32'sd0);
    push_item(ACT_RELAX, 16'hA5A5, 16'h0000, POT_MIN);
    push_item(ACT_RELAX, 16'hA5A5, 16'h5A5A, POT_MAX);
    push_item(ACT_RELAX, 16'hA5A5, 16'hFFFF, -32'sd1);
    push_item(ACT_RELAX, 16'h0000, 16'h5A5A, 32'sd5);
    for (int e = 0; e < EDGES_PER_NODE; e++)
      push_item(ACT_RELAX, 16'h5A5A, 16'hA5A5, POT_MAX);
    drain();

    for (int p = 0; p < 4; p++) begin
      write_threshold(thr_values[p]);
      send_idle_pct  = send_pcts[p];
      recv_stall_pct = recv_pcts[p];
      add_random(PHASE_ITEMS);
      drain();
    end

    if (error_count == 0 && expected_results.size() == 0) begin
      $display("min_plus_relaxation_sweep: match");
    end else begin
      $display("min_plus_relaxation_sweep: mismatch");
    end
    $finish;
  end

endmodule
